FILE: rtl/axis_angle_vector_rotate_macros.svh
// Assertion macros shared by the rotation block.
`ifndef AXIS_ANGLE_VECTOR_ROTATE_MACROS_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define AAVR_ASSERT_IMP(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked through reset as well.
`define AAVR_ASSERT_RST(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/aavr_pkg.sv
// Shared constants, tables and types of the axis-angle rotation block.
`default_nettype none
package aavr_pkg;
   localparam int CORDIC_STAGES_DEF  = 16;
   localparam int TRIG_FRAC_BITS_DEF = 14;
   localparam int ATAN_ENTRIES       = 24;

   localparam int VEC_W  = 32;
   localparam int AXIS_W = 16;
   localparam int ANG_W  = 18;
   localparam int RED_W  = 19;
   localparam int XY_W   = 34;
   localparam int Z_W    = 33;

   localparam int FULL_TURN    = 92160;
   localparam int HALF_TURN    = 46080;
   localparam int QUARTER_TURN = 23040;

   // fixed scale of the axis times sine term
   localparam int AXIS_SHIFT  = 14;
   localparam int ENTRY_SHIFT = 28;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

   // atan(2^-i) in 2^-24 degree
   localparam int ATAN_TAB [ATAN_ENTRIES] = '{
      754974720, 445687602, 235489089, 119537938, 60000935, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115
   };

   typedef struct packed {
      logic                     valid;
      logic                     neg_cos;
      logic signed [XY_W-1:0]   x;
      logic signed [XY_W-1:0]   y;
      logic signed [Z_W-1:0]    z;
      logic [2:0][VEC_W-1:0]    vec;
      logic [2:0][AXIS_W-1:0]   axis;
   } cell_data_type;
endpackage
`default_nettype wire

FILE: rtl/aavr_cordic_cell.sv
// One CORDIC rotation cell of the sine/cosine chain.
`default_nettype none
module aavr_cordic_cell #(
   parameter int STAGE = 0
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     adv,
   input  aavr_pkg::cell_data_type d_in,
   output aavr_pkg::cell_data_type d_out
);
   localparam logic signed [aavr_pkg::Z_W-1:0] ATAN =
      aavr_pkg::Z_W'(aavr_pkg::ATAN_TAB[STAGE]);

   aavr_pkg::cell_data_type d_in_c;
   aavr_pkg::cell_data_type d_ff;

   always_comb begin
      d_in_c = d_in;
      if (!d_in.z[aavr_pkg::Z_W-1]) begin
         d_in_c.x = $signed(d_in.x) - ($signed(d_in.y) >>> STAGE);
         d_in_c.y = $signed(d_in.y) + ($signed(d_in.x) >>> STAGE);
         d_in_c.z = $signed(d_in.z) - ATAN;
      end else begin
         d_in_c.x = $signed(d_in.x) + ($signed(d_in.y) >>> STAGE);
         d_in_c.y = $signed(d_in.y) - ($signed(d_in.x) >>> STAGE);
         d_in_c.z = $signed(d_in.z) + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.valid <= 1'b0;
      end else if (adv) begin
         d_ff <= d_in_c;
      end
   end

   assign d_out = d_ff;
endmodule
`default_nettype wire

FILE: rtl/aavr_rotate.sv
// Trig rounding, rotation matrix build and vector-times-matrix with saturation.
`default_nettype none
module aavr_rotate #(
   parameter int TRIG_FRAC_BITS = aavr_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     adv,
   input  aavr_pkg::cell_data_type d_in,
   output logic                    out_valid,
   output logic [3*aavr_pkg::VEC_W-1:0] out_rot,
   output logic                    out_sat
);
   localparam int F     = TRIG_FRAC_BITS;
   localparam int SH    = 30 - F;
   localparam int XW    = aavr_pkg::XY_W + 1;
   localparam int TW    = F + 3;
   localparam int OW    = TW + 1;
   localparam int PAA   = 2 * aavr_pkg::AXIS_W;
   localparam int PAS   = aavr_pkg::AXIS_W + TW;
   localparam int SUM_W = PAA + TW + 4;
   localparam int M_W   = F + 6;
   localparam int VW    = aavr_pkg::VEC_W;
   localparam int PV_W  = VW + M_W;
   localparam int TS_W  = PV_W + 2;

   logic [5:0] vld_ff;

   // stage 0: round sine and cosine
   logic signed [XW-1:0] cx_sum, sy_sum, cx_sh, sy_sh;
   logic signed [TW-1:0] cos0_in, sin0_in, cos0_ff, sin0_ff;
   logic [2:0][VW-1:0] vec0_ff, vec1_ff, vec2_ff, vec3_ff;
   logic [2:0][aavr_pkg::AXIS_W-1:0] axis0_ff;

   assign cx_sum = $signed({d_in.x[aavr_pkg::XY_W-1], d_in.x}) + $signed(XW'(1) << (SH - 1));
   assign sy_sum = $signed({d_in.y[aavr_pkg::XY_W-1], d_in.y}) + $signed(XW'(1) << (SH - 1));
   assign cx_sh  = cx_sum >>> SH;
   assign sy_sh  = sy_sum >>> SH;
   assign sin0_in = sy_sh[TW-1:0];
   assign cos0_in = d_in.neg_cos ? -cx_sh[TW-1:0] : cx_sh[TW-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         cos0_ff  <= cos0_in;
         sin0_ff  <= sin0_in;
         vec0_ff  <= d_in.vec;
         axis0_ff <= d_in.axis;
      end
   end

   // stage 1: axis products
   logic signed [aavr_pkg::AXIS_W-1:0] ax [3];
   logic signed [PAA-1:0] aa_in [6];
   logic signed [PAA-1:0] aa_ff [6];
   logic signed [PAS-1:0] as_in [3];
   logic signed [PAS-1:0] as_ff [3];
   logic signed [OW-1:0]  omc_in, omc_ff;
   logic signed [TW-1:0]  cos1_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ax[j]    = $signed(axis0_ff[j]);
         aa_in[j] = ax[j] * ax[j];
         as_in[j] = PAS'(ax[j]) * PAS'(sin0_ff);
      end
      aa_in[3] = ax[0] * ax[1];
      aa_in[4] = ax[0] * ax[2];
      aa_in[5] = ax[1] * ax[2];
      omc_in   = $signed(OW'(1) << F) - OW'(cos0_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         aa_ff   <= aa_in;
         as_ff   <= as_in;
         omc_ff  <= omc_in;
         cos1_ff <= cos0_ff;
         vec1_ff <= vec0_ff;
      end
   end

   // stage 2: matrix terms in Q(28+F)
   logic signed [PAA:0]     onem [3];
   logic signed [SUM_W-1:0] diag_in [3], diag_ff [3];
   logic signed [SUM_W-1:0] base_in [3], base_ff [3];
   logic signed [SUM_W-1:0] asft_in [3], asft_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         onem[j]    = $signed((PAA + 1)'(1) << aavr_pkg::ENTRY_SHIFT) - (PAA + 1)'(aa_ff[j]);
         diag_in[j] = (SUM_W'(aa_ff[j]) <<< F) + SUM_W'(onem[j]) * SUM_W'(cos1_ff);
         base_in[j] = SUM_W'(aa_ff[3 + j]) * SUM_W'(omc_ff);
         asft_in[j] = SUM_W'(as_ff[j]) <<< aavr_pkg::AXIS_SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diag_ff <= diag_in;
         base_ff <= base_in;
         asft_ff <= asft_in;
         vec2_ff <= vec1_ff;
      end
   end

   // stage 3: combine and round entries to QF
   logic signed [SUM_W-1:0] raw [3][3];
   logic signed [SUM_W-1:0] rnd [3][3];
   logic signed [M_W-1:0]   m_in [3][3];
   logic signed [M_W-1:0]   m_ff [3][3];

   always_comb begin
      raw[0][0] = diag_ff[0];
      raw[1][1] = diag_ff[1];
      raw[2][2] = diag_ff[2];
      raw[0][1] = base_ff[0] - asft_ff[2];
      raw[1][0] = base_ff[0] + asft_ff[2];
      raw[0][2] = base_ff[1] + asft_ff[1];
      raw[2][0] = base_ff[1] - asft_ff[1];
      raw[1][2] = base_ff[2] - asft_ff[0];
      raw[2][1] = base_ff[2] + asft_ff[0];
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            rnd[r][c]  = (raw[r][c] + $signed(SUM_W'(1) << (aavr_pkg::ENTRY_SHIFT - 1)))
                         >>> aavr_pkg::ENTRY_SHIFT;
            m_in[r][c] = rnd[r][c][M_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff    <= m_in;
         vec3_ff <= vec2_ff;
      end
   end

   // stage 4: vector times entries
   logic signed [PV_W-1:0] p_in [3][3];
   logic signed [PV_W-1:0] p_ff [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            p_in[r][c] = PV_W'($signed(vec3_ff[r])) * PV_W'(m_ff[r][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= p_in;
      end
   end

   // stage 5: column sums, round to Q16.16, clamp
   logic signed [TS_W-1:0] ts [3];
   logic signed [TS_W-1:0] tsh [3];
   logic [TS_W-32:0]       hi [3];
   logic [2:0]             ovf;
   logic [3*VW-1:0]        rot_in, rot_ff;
   logic                   sat_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ts[c]  = TS_W'(p_ff[0][c]) + TS_W'(p_ff[1][c]) + TS_W'(p_ff[2][c])
                  + $signed(TS_W'(1) << (F - 1));
         tsh[c] = ts[c] >>> F;
         hi[c]  = tsh[c][TS_W-1:VW-1];
         ovf[c] = !((&hi[c]) || !(|hi[c]));
         if (ovf[c]) begin
            rot_in[c*VW +: VW] = tsh[c][TS_W-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
         end else begin
            rot_in[c*VW +: VW] = tsh[c][VW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_ff <= rot_in;
         sat_ff <= |ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[4:0], d_in.valid};
      end
   end

   assign out_valid = vld_ff[5];
   assign out_rot   = rot_ff;
   assign out_sat   = sat_ff;
endmodule
`default_nettype wire

FILE: rtl/axis_angle_vector_rotate.sv
// Path from request to result: the input register, the CORDIC cell chain, then the aavr_rotate stages;
// capped stage count of 24 cells in the sine/cosine chain.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits on rsp_tready, and the output register frees as soon as it is taken.
// Reset clears all stage valid bits synchronously; data registers are not reset.
`default_nettype none
`include "axis_angle_vector_rotate_macros.svh"
module axis_angle_vector_rotate #(
   parameter int CORDIC_STAGES  = aavr_pkg::CORDIC_STAGES_DEF,
   parameter int TRIG_FRAC_BITS = aavr_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle in 1/256 degree, zero fill
   input  wire [167:0]  req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // rot_x, rot_y, rot_z
   output logic [95:0]  rsp_tdata,
   // saturated
   output logic         rsp_tuser
);
   localparam int N = (CORDIC_STAGES < aavr_pkg::ATAN_ENTRIES) ?
                      CORDIC_STAGES : aavr_pkg::ATAN_ENTRIES;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // reduce the angle to [-90, 90] degrees, note a cosine flip
   logic signed [aavr_pkg::ANG_W-1:0] ang;
   logic signed [aavr_pkg::RED_W-1:0] r0, r1, r2, r3;
   logic neg;
   aavr_pkg::cell_data_type s0_in, s0_ff;

   assign ang = $signed(req_tdata[161:144]);
   assign r0  = aavr_pkg::RED_W'(ang);

   always_comb begin
      priority if (r0 >= aavr_pkg::FULL_TURN) begin
         r1 = aavr_pkg::RED_W'(r0 - aavr_pkg::FULL_TURN);
      end else if (r0 <= -aavr_pkg::FULL_TURN) begin
         r1 = aavr_pkg::RED_W'(r0 + aavr_pkg::FULL_TURN);
      end else begin
         r1 = r0;
      end
      priority if (r1 >= aavr_pkg::HALF_TURN) begin
         r2 = aavr_pkg::RED_W'(r1 - aavr_pkg::FULL_TURN);
      end else if (r1 < -aavr_pkg::HALF_TURN) begin
         r2 = aavr_pkg::RED_W'(r1 + aavr_pkg::FULL_TURN);
      end else begin
         r2 = r1;
      end
      neg = 1'b0;
      priority if (r2 > aavr_pkg::QUARTER_TURN) begin
         r3  = aavr_pkg::RED_W'(aavr_pkg::HALF_TURN - r2);
         neg = 1'b1;
      end else if (r2 < -aavr_pkg::QUARTER_TURN) begin
         r3  = aavr_pkg::RED_W'(-aavr_pkg::HALF_TURN - r2);
         neg = 1'b1;
      end else begin
         r3 = r2;
      end

      s0_in.valid   = req_tvalid;
      s0_in.neg_cos = neg;
      s0_in.x       = aavr_pkg::CORDIC_GAIN;
      s0_in.y       = '0;
      s0_in.z       = {r3[16:0], 16'b0};
      s0_in.vec     = req_tdata[95:0];
      s0_in.axis    = req_tdata[143:96];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (adv) begin
         s0_ff <= s0_in;
      end
   end

   aavr_pkg::cell_data_type chain [N+1];
   assign chain[0] = s0_ff;

   for (genvar i = 0; i < N; i++) begin : g_cell
      aavr_cordic_cell #(.STAGE(i)) u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .d_in  (chain[i]),
         .d_out (chain[i+1])
      );
   end

   aavr_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .d_in      (chain[N]),
      .out_valid (rsp_tvalid),
      .out_rot   (rsp_tdata),
      .out_sat   (rsp_tuser)
   );

   `AAVR_ASSERT_IMP(a_stall_blocks_req, rsp_tvalid && !rsp_tready, !req_tready, "request taken while result stalled")
   `AAVR_ASSERT_IMP(a_sat_at_bound, rsp_tvalid && rsp_tuser, (rsp_tdata[31:0] == 32'h7fffffff) || (rsp_tdata[31:0] == 32'h80000000) || (rsp_tdata[63:32] == 32'h7fffffff) || (rsp_tdata[63:32] == 32'h80000000) || (rsp_tdata[95:64] == 32'h7fffffff) || (rsp_tdata[95:64] == 32'h80000000), "saturated flag without clamped component")
   `AAVR_ASSERT_RST(a_reset_empty, reset, !rsp_tvalid, "result valid after reset")
endmodule
`default_nettype wire

FILE: verif/tb_axis_angle_vector_rotate.sv
// Testbench for the axis-angle vector rotation block: random and directed requests, scoreboard.
`timescale 1ns / 100ps
`default_nettype none

class rotate_scoreboard;
   typedef struct {
      logic signed [31:0] rx, ry, rz;
      logic               sat;
   } rot_result_type;

   rot_result_type pending_q[$];
   int unsigned mismatch_count;

   // atan(2^-i) in 2^-24 degree
   longint atan_lut[24] = '{
      754974720, 445687602, 235489089, 119537938, 60000935, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115};

   function new();
      mismatch_count = 0;
   endfunction

   // floor division by 2^s
   function longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function void trig_of(longint ang, output longint sn, output longint cs);
      longint r, x, y, z, nx, half, cv;
      bit     flip;
      r = ang % aavr_pkg::FULL_TURN;
      flip = 0;
      if (r >= aavr_pkg::HALF_TURN) r -= aavr_pkg::FULL_TURN;
      if (r < -aavr_pkg::HALF_TURN) r += aavr_pkg::FULL_TURN;
      if (r > aavr_pkg::QUARTER_TURN) begin
         r = aavr_pkg::HALF_TURN - r;
         flip = 1;
      end else if (r < -aavr_pkg::QUARTER_TURN) begin
         r = -aavr_pkg::HALF_TURN - r;
         flip = 1;
      end
      x = 652032874;
      y = 0;
      z = r * 65536;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z -= atan_lut[i];
         end else begin
            nx = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z += atan_lut[i];
         end
         x = nx;
      end
      half = 64'sd1 << 15;
      cv = floor_shift(x + half, 16);
      sn = floor_shift(y + half, 16);
      cs = flip ? -cv : cv;
   endfunction

   function longint to_entry(longint v);
      return floor_shift(v + (64'sd1 << 27), 28);
   endfunction

   function void note_request(logic [167:0] d);
      longint v[3], a[3], m[3][3], s, c, omc, t;
      rot_result_type e;
      for (int j = 0; j < 3; j++) begin
         v[j] = longint'($signed(d[32*j +: 32]));
         a[j] = longint'($signed(d[96 + 16*j +: 16]));
      end
      trig_of(longint'($signed(d[144 +: 18])), s, c);
      omc = 16384 - c;
      for (int j = 0; j < 3; j++)
         m[j][j] = to_entry(a[j] * a[j] * 16384 + ((64'sd1 << 28) - a[j] * a[j]) * c);
      m[0][1] = to_entry(a[0] * a[1] * omc - a[2] * s * 16384);
      m[1][0] = to_entry(a[0] * a[1] * omc + a[2] * s * 16384);
      m[0][2] = to_entry(a[0] * a[2] * omc + a[1] * s * 16384);
      m[2][0] = to_entry(a[0] * a[2] * omc - a[1] * s * 16384);
      m[1][2] = to_entry(a[1] * a[2] * omc - a[0] * s * 16384);
      m[2][1] = to_entry(a[1] * a[2] * omc + a[0] * s * 16384);
      e.sat = 0;
      for (int j = 0; j < 3; j++) begin
         t = v[0] * m[0][j] + v[1] * m[1][j] + v[2] * m[2][j];
         t = floor_shift(t + 8192, 14);
         if (t > 64'sd2147483647) begin
            t = 64'sd2147483647;
            e.sat = 1;
         end else if (t < -64'sd2147483648) begin
            t = -64'sd2147483648;
            e.sat = 1;
         end
         if (j == 0) e.rx = t[31:0];
         else if (j == 1) e.ry = t[31:0];
         else e.rz = t[31:0];
      end
      pending_q.push_back(e);
   endfunction

   function void check_result(logic [95:0] d, logic sat);
      rot_result_type e;
      if (pending_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result %h sat %b", d, sat);
         return;
      end
      e = pending_q.pop_front();
      if (d[31:0] !== e.rx || d[63:32] !== e.ry || d[95:64] !== e.rz || sat !== e.sat) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("rot exp %0d %0d %0d sat %b, got %0d %0d %0d sat %b",
               e.rx, e.ry, e.rz, e.sat, $signed(d[31:0]), $signed(d[63:32]),
               $signed(d[95:64]), sat);
      end
   endfunction
endclass

module tb_axis_angle_vector_rotate;
   localparam int N_RANDOM  = 830;
   localparam int CYCLE_CAP = 200000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [95:0]  rsp_tdata;
   logic         rsp_tuser;

   rotate_scoreboard board = new();
   bit   calm = 0;
   int   cycle_count = 0;
   int   sent = 0;

   axis_angle_vector_rotate uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser));

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_tvalid && req_tready) board.note_request(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
      if (cycle_count > CYCLE_CAP) begin
         $display("axis_angle_vector_rotate: mismatch");
         $finish;
      end
   end

   // random receiver stalls in bursts, none in the calm tail
   initial begin : rsp_side
      int n;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 6);
            rsp_tready <= 0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_tready <= 1;
            @(negedge clock);
         end
      end
   end

   task automatic send_rotation(logic [31:0] vx, vy, vz, logic [15:0] ax, ay, az,
                                logic [17:0] ang);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 6);
         req_tvalid <= 0;
         repeat (n) @(negedge clock);
      end
      req_tdata  <= {6'b0, ang, az, ay, ax, vz, vy, vx};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   function automatic logic [15:0] unit_axis_part();
      case ($urandom_range(0, 3))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic [17:0] any_angle();
      case ($urandom_range(0, 3))
         0: return 18'($signed($urandom_range(0, 184320)) - 92160);
         1: return 18'($urandom_range(0, 8) * 11520);
         2: return 18'(-$signed($urandom_range(0, 8) * 11520));
         default: return 18'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] any_coord();
      case ($urandom_range(0, 3))
         0: return 32'($signed($urandom_range(0, 2000000)) - 1000000) <<< 8;
         1: return $urandom;
         2: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 200000)) - 100000);
      endcase
   endfunction

   initial begin : req_side
      int wait_n;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: identity, quarter turns, half turn, folds, extremes, odd axes
      send_rotation(32'h00010000, 32'h00020000, 32'h00030000, 16384, 0, 0, 0);
      send_rotation(32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 16384, 23040);
      send_rotation(32'h00010000, 32'h00020000, 32'h00030000, 0, 16384, 0, -23040);
      send_rotation(32'h00010000, 32'h00020000, 32'h00030000, 16384, 0, 0, 46080);
      send_rotation(32'h00010000, 0, 0, 0, 0, 16384, -46080);
      send_rotation(32'h00010000, 0, 0, 0, 0, 16384, 92160);
      send_rotation(32'h00010000, 0, 0, 0, 0, 16384, -92160);
      send_rotation(32'h00010000, 0, 0, 0, 0, 16384, 30000);
      send_rotation(32'h00010000, 0, 0, 0, 0, 16384, -30000);
      send_rotation(32'h00010000, 0, 0, 0, 0, 16384, 18'h1ffff);
      send_rotation(32'h00010000, 0, 0, 0, 0, 16384, 18'h20000);
      send_rotation(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff, 16'h7fff, 11520);
      send_rotation(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000, -11520);
      send_rotation(32'h7fffffff, 32'h80000000, 0, 0, 0, 16384, 0);
      send_rotation(32'h7fffffff, 32'h7fffffff, 0, 0, 0, 16384, 11520);
      send_rotation(32'h80000000, 32'h80000000, 0, 0, 0, 16384, -11520);
      send_rotation(32'h00050000, 32'hfffb0000, 32'h00010000, 9459, 9459, 9459, 30720);
      send_rotation(32'h00050000, 32'hfffb0000, 32'h00010000, 0, 0, 0, 12345);
      send_rotation(32'hffffffff, 1, 32'h12345678, 16'h7fff, 16'h8000, 16'h0001, 7);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i > N_RANDOM - 100) calm = 1;
         if ($urandom_range(0, 4) == 0)
            send_rotation($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                          16'($urandom), 18'($urandom));
         else
            send_rotation(any_coord(), any_coord(), any_coord(), unit_axis_part(),
                          unit_axis_part(), unit_axis_part(), any_angle());
      end
      req_tvalid <= 0;
      while (board.pending_q.size() != 0) @(posedge clock);
      wait_n = 0;
      while (wait_n < 40) begin
         @(posedge clock);
         wait_n++;
      end
      if (board.mismatch_count == 0)
         $display("axis_angle_vector_rotate: match");
      else
         $display("axis_angle_vector_rotate: mismatch");
      $finish;
   end
endmodule

`default_nettype wire
